// ----- src/otsb_pkg.sv -----
// Shared types and constants for the one-shot timer bank.
// Used by otsb_div and one_shot_timer_bank_unit; depends on nothing.
package otsb_pkg;

   localparam int NUM_TIMERS_DEF = 16;
   localparam int MAX_RESULTS    = 16;
   localparam int MS_PER_SEC     = 1000;
   localparam int DIV_IN_W       = 33;                  // wrapped delta plus leftover
   localparam int REM_W          = $clog2(MS_PER_SEC);  // remainder stays below 1000

   // request codes
   localparam logic [2:0] ACT_TICK        = 3'd0;
   localparam logic [2:0] ACT_ALLOC_FIRST = 3'd1;
   localparam logic [2:0] ACT_ALLOC_AT    = 3'd2;
   localparam logic [2:0] ACT_DELETE      = 3'd3;
   localparam logic [2:0] ACT_ENABLE      = 3'd4;
   localparam logic [2:0] ACT_DISABLE     = 3'd5;

   typedef enum logic [1:0] {
      KIND_STATUS    = 2'd0,
      KIND_FIRED     = 2'd1,
      KIND_IDLE_TICK = 2'd2
   } otsb_kind_type;

   typedef enum logic [1:0] {
      STS_OK        = 2'd0,
      STS_RANGE     = 2'd1,
      STS_IN_USE    = 2'd2,
      STS_NO_FREE   = 2'd3
   } otsb_status_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [7:0]  slot_index;
      logic [31:0] delay_sec;
      logic [31:0] now_ms;
   } otsb_req_type;

   typedef struct packed {
      otsb_kind_type   kind;
      otsb_status_type status;
      logic [7:0]      result_index;
      logic [31:0]     seconds_now;
      logic            last;
   } otsb_rsp_type;

   typedef struct packed {
      logic             done;
      logic [31:0]      quotient;
      logic [REM_W-1:0] remainder;
   } otsb_div_res_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_FINISH,
      ST_EN_RD,
      ST_CMD
   } otsb_state_type;

endpackage

// ----- src/otsb_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module otsb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/otsb_div.sv -----
// Divide by MS_PER_SEC through a pipelined reciprocal multiply; start passes through load_ff and mul_ff to done_ff.
// Depends on otsb_pkg.
module otsb_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [otsb_pkg::DIV_IN_W-1:0]   dividend,
   output otsb_pkg::otsb_div_res_type      res
);
   import otsb_pkg::*;

   // x / 1000 = (x >> 3) / 125; the low three bits go straight to the remainder
   localparam int          LO_W    = 3;
   localparam int          ODD_DIV = MS_PER_SEC >> LO_W;
   localparam int          Y_W     = DIV_IN_W - LO_W;
   localparam int          SHIFT   = 37;
   localparam int          PROD_W  = Y_W + 31;
   localparam logic [30:0] RECIP   =
      31'(((64'd1 << SHIFT) + 64'(ODD_DIV) - 64'd1) / 64'(ODD_DIV));

   logic [DIV_IN_W-1:0]     x_ff;
   logic [PROD_W-1:0]       prod_ff;
   logic [31:0]             quot_ff;
   logic [REM_W-1:0]        rem_ff;
   logic                    load_ff;
   logic                    mul_ff;
   logic                    done_ff;
   logic [PROD_W-SHIFT-1:0] q_calc;
   logic [13:0]             q_lo_mul;
   logic [6:0]              r_odd;

   assign q_calc   = prod_ff[PROD_W-1:SHIFT];
   // remainder of the odd part is below 128, so seven bits of the difference suffice
   assign q_lo_mul = 14'(q_calc[6:0]) * 14'(ODD_DIV);
   assign r_odd    = x_ff[LO_W+6:LO_W] - q_lo_mul[6:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= 1'b0;
         mul_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         load_ff <= start;
         mul_ff  <= load_ff;
         done_ff <= mul_ff;
      end
      if (start) begin
         x_ff <= dividend;
      end
      if (load_ff) begin
         prod_ff <= PROD_W'(x_ff[DIV_IN_W-1:LO_W]) * PROD_W'(RECIP);
      end
      if (mul_ff) begin
         quot_ff <= 32'(q_calc);
         rem_ff  <= {r_odd, x_ff[LO_W-1:0]};
      end
   end

   assign res.done      = done_ff;
   assign res.quotient  = quot_ff;
   assign res.remainder = rem_ff;

endmodule

// ----- src/one_shot_timer_bank_unit.sv -----
// One request at a time. A command passes through ST_CMD (enable: ST_EN_RD, then ST_CMD) and may
// wait there on rsp_stall. A tick divides the elapsed milliseconds by 1000 (a pipelined reciprocal
// multiply), then reads and compares the deadline memory for each slot, pushes the closing result
// and returns to idle; each fired result may wait on rsp_stall. Delays and deadlines live in two
// RAMs; used and enable marks are flops. No clearing pass after reset.
module one_shot_timer_bank_unit #(
   parameter int NUM_TIMERS = otsb_pkg::NUM_TIMERS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  otsb_pkg::otsb_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output otsb_pkg::otsb_rsp_type rsp_data
);
   import otsb_pkg::*;

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W = $clog2(MAX_RESULTS + 1);

   otsb_state_type          state_ff, state_in;
   otsb_req_type            req_ff;
   logic [31:0]             last_ms_ff, last_ms_in;
   logic [REM_W-1:0]        leftover_ff, leftover_in;
   logic [31:0]             seconds_ff, seconds_in;
   logic [NUM_TIMERS-1:0]   used_ff, used_in;
   logic [NUM_TIMERS-1:0]   enabled_ff, enabled_in;
   logic [NUM_TIMERS-1:0]   dly_valid_ff, dly_valid_in;
   logic [IDX_W-1:0]        scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0]        fired_cnt_ff, fired_cnt_in;
   logic                    pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]        pend_idx_ff, pend_idx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   otsb_rsp_type            rsp_ff, push_data;
   logic                    push;

   logic                    accept;
   logic                    out_free;
   logic                    in_range;
   logic [IDX_W-1:0]        sel;
   logic                    free_found;
   logic [IDX_W-1:0]        free_idx;
   logic                    scan_hit, scan_go, scan_last;

   logic                    div_start;
   logic [DIV_IN_W-1:0]     div_dividend;
   otsb_div_res_type        div_res;

   logic                    dly_wr_en, dly_rd_en;
   logic [IDX_W-1:0]        dly_wr_addr;
   logic [31:0]             dly_rd_data;
   logic                    dl_wr_en, dl_rd_en;
   logic [31:0]             dl_wr_data, dl_rd_data;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign in_range  = (req_ff.slot_index < 8'(NUM_TIMERS));
   assign sel       = req_ff.slot_index[IDX_W-1:0];

   // lowest unused slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   // a hit must first hand the previous fired slot to the output register
   assign scan_hit  = enabled_ff[scan_idx_ff] && (dl_rd_data <= seconds_ff);
   assign scan_go   = !(scan_hit && pend_valid_ff && !out_free);
   assign scan_last = (scan_idx_ff == IDX_W'(NUM_TIMERS - 1)) ||
                      (scan_hit && (fired_cnt_ff == CNT_W'(MAX_RESULTS - 1)));

   assign div_start    = accept && (req_data.action == ACT_TICK);
   assign div_dividend = {1'b0, req_data.now_ms - last_ms_ff} + DIV_IN_W'(leftover_ff);

   otsb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .res      (div_res)
   );

   assign dly_rd_en = (state_ff == ST_EN_RD) && in_range;
   assign dl_rd_en  = (state_ff == ST_SCAN_RD);

   otsb_ram #(.WIDTH(32), .DEPTH(NUM_TIMERS)) u_delay_ram (
      .clock   (clock),
      .wr_en   (dly_wr_en),
      .wr_addr (dly_wr_addr),
      .wr_data (req_ff.delay_sec),
      .rd_en   (dly_rd_en),
      .rd_addr (sel),
      .rd_data (dly_rd_data)
   );

   otsb_ram #(.WIDTH(32), .DEPTH(NUM_TIMERS)) u_deadline_ram (
      .clock   (clock),
      .wr_en   (dl_wr_en),
      .wr_addr (sel),
      .wr_data (dl_wr_data),
      .rd_en   (dl_rd_en),
      .rd_addr (scan_idx_ff),
      .rd_data (dl_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.action == ACT_TICK) begin
                  state_in = ST_DIV;
               end else if (req_data.action == ACT_ENABLE) begin
                  state_in = ST_EN_RD;
               end else begin
                  state_in = ST_CMD;
               end
            end
         end
         ST_DIV: begin
            if (div_res.done) begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: state_in = ST_SCAN_CMP;
         ST_SCAN_CMP: begin
            if (scan_go) begin
               state_in = scan_last ? ST_FINISH : ST_SCAN_RD;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_EN_RD: state_in = ST_CMD;
         ST_CMD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      last_ms_in    = last_ms_ff;
      leftover_in   = leftover_ff;
      seconds_in    = seconds_ff;
      used_in       = used_ff;
      enabled_in    = enabled_ff;
      dly_valid_in  = dly_valid_ff;
      scan_idx_in   = scan_idx_ff;
      fired_cnt_in  = fired_cnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      dly_wr_en     = 1'b0;
      dly_wr_addr   = sel;
      dl_wr_en      = 1'b0;
      dl_wr_data    = seconds_ff + (dly_valid_ff[sel] ? dly_rd_data : 32'd0);
      push          = 1'b0;
      push_data.kind         = KIND_STATUS;
      push_data.status       = STS_OK;
      push_data.result_index = '0;
      push_data.seconds_now  = seconds_ff;
      push_data.last         = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (div_start) begin
               last_ms_in    = req_data.now_ms;
               scan_idx_in   = '0;
               fired_cnt_in  = '0;
               pend_valid_in = 1'b0;
            end
         end
         ST_DIV: begin
            if (div_res.done) begin
               seconds_in  = seconds_ff + div_res.quotient;
               leftover_in = div_res.remainder;
            end
         end
         ST_SCAN_CMP: begin
            if (scan_go) begin
               if (scan_hit) begin
                  enabled_in[scan_idx_ff] = 1'b0;
                  fired_cnt_in            = fired_cnt_ff + 1'b1;
                  pend_valid_in           = 1'b1;
                  pend_idx_in             = scan_idx_ff;
                  if (pend_valid_ff) begin
                     push                   = 1'b1;
                     push_data.kind         = KIND_FIRED;
                     push_data.result_index = 8'(pend_idx_ff);
                     push_data.last         = 1'b0;
                  end
               end
               if (!scan_last) begin
                  scan_idx_in = scan_idx_ff + 1'b1;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               push          = 1'b1;
               pend_valid_in = 1'b0;
               if (pend_valid_ff) begin
                  push_data.kind         = KIND_FIRED;
                  push_data.result_index = 8'(pend_idx_ff);
               end else begin
                  push_data.kind = KIND_IDLE_TICK;
               end
            end
         end
         ST_CMD: begin
            if (out_free) begin
               push = 1'b1;
               unique case (req_ff.action)
                  ACT_ALLOC_FIRST: begin
                     if (free_found) begin
                        used_in[free_idx]      = 1'b1;
                        dly_valid_in[free_idx] = 1'b1;
                        dly_wr_en              = 1'b1;
                        dly_wr_addr            = free_idx;
                        push_data.result_index = 8'(free_idx);
                     end else begin
                        push_data.status = STS_NO_FREE;
                     end
                  end
                  ACT_ALLOC_AT: begin
                     if (!in_range) begin
                        push_data.status = STS_RANGE;
                     end else if (used_ff[sel]) begin
                        push_data.status = STS_IN_USE;
                     end else begin
                        used_in[sel]           = 1'b1;
                        dly_valid_in[sel]      = 1'b1;
                        dly_wr_en              = 1'b1;
                        push_data.result_index = 8'(sel);
                     end
                  end
                  ACT_DELETE: begin
                     if (!in_range) begin
                        push_data.status = STS_RANGE;
                     end else begin
                        used_in[sel]    = 1'b0;
                        enabled_in[sel] = 1'b0;
                     end
                  end
                  ACT_ENABLE: begin
                     if (!in_range) begin
                        push_data.status = STS_RANGE;
                     end else begin
                        dl_wr_en        = 1'b1;
                        enabled_in[sel] = 1'b1;
                     end
                  end
                  ACT_DISABLE: begin
                     if (!in_range) begin
                        push_data.status = STS_RANGE;
                     end else begin
                        enabled_in[sel] = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase

      rsp_valid_in = push || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         last_ms_ff    <= '0;
         leftover_ff   <= '0;
         seconds_ff    <= '0;
         used_ff       <= '0;
         enabled_ff    <= '0;
         dly_valid_ff  <= '0;
         pend_valid_ff <= 1'b0;
         fired_cnt_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_ms_ff    <= last_ms_in;
         leftover_ff   <= leftover_in;
         seconds_ff    <= seconds_in;
         used_ff       <= used_in;
         enabled_ff    <= enabled_in;
         dly_valid_ff  <= dly_valid_in;
         pend_valid_ff <= pend_valid_in;
         fired_cnt_ff  <= fired_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      scan_idx_ff <= scan_idx_in;
      pend_idx_ff <= pend_idx_in;
      if (accept) begin
         req_ff <= req_data;
      end
      if (push) begin
         rsp_ff <= push_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_pend_in_scan: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (state_ff == ST_SCAN_RD || state_ff == ST_SCAN_CMP ||
                         state_ff == ST_FINISH))
      else $error("pending fired slot outside a tick scan");

   a_fire_limit: assert property (@(posedge clock) disable iff (reset)
      fired_cnt_ff <= CNT_W'(MAX_RESULTS))
      else $error("too many slots fired in one tick");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide state");

   a_fire_disables: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN_CMP && scan_go && scan_hit) |=> !enabled_ff[$past(scan_idx_ff)])
      else $error("fired slot still enabled");

endmodule
